>>> hw/rtl/pei_pkg.sv
`timescale 1ns / 1ps

package pei_pkg;

    localparam int unsigned NUM_AXES   = 3;
    localparam int unsigned DATA_W     = 32;
    localparam int unsigned CFG_ADDR_W = 3;

    // operand and product widths of the per-lane multiplier
    localparam int unsigned MUL_W  = 33;
    localparam int unsigned PROD_W = 2 * MUL_W;
    localparam int unsigned MAG_W  = 64;

    // signed quotient after clamping (+/- 2^32 marks overflow)
    localparam int unsigned QS_W  = 34;
    // acceleration accumulator: five terms of 32 bits
    localparam int unsigned ACC_W = 35;

    // divider: quotient bits retired per cycle
    localparam int unsigned DIV_STEPS  = 2;
    localparam int unsigned DIV_CYCLES = DATA_W / DIV_STEPS;
    localparam int unsigned DIV_CNT_W  = $clog2(DIV_CYCLES);

    localparam logic [DATA_W-1:0] MS_PER_S = 32'd1000;
    localparam logic [DATA_W-1:0] Q16_ONE  = 32'd65536;

    // per-request coefficients shared by all lanes
    typedef struct packed {
        logic        [30:0]       drag;
        logic        [DATA_W-1:0] mass;
        logic signed [DATA_W-1:0] gain;
        logic signed [DATA_W-1:0] damp;
        logic                     follow;
        logic        [DATA_W-1:0] delta;
    } job_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] vel;
        logic signed [DATA_W-1:0] pos;
        logic signed [DATA_W-1:0] tgt;
        logic signed [DATA_W-1:0] force_c;
        logic signed [ACC_W-1:0]  acc_init;
    } axis_in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] vel;
        logic signed [DATA_W-1:0] pos;
    } axis_out_t;

endpackage

>>> hw/rtl/pei_div.sv
`timescale 1ns / 1ps

module pei_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [pei_pkg::MAG_W-1:0]    dividend,
    input  logic [pei_pkg::DATA_W-1:0]   divisor,
    output logic                         done,
    output logic                         ovf,
    output logic [pei_pkg::DATA_W-1:0]   quot
);

    localparam logic [pei_pkg::DIV_CNT_W-1:0] CNT_LAST =
        pei_pkg::DIV_CNT_W'(pei_pkg::DIV_CYCLES - 1);

    logic                               busy_reg;
    logic                               done_reg;
    logic [pei_pkg::DIV_CNT_W-1:0]      cnt_reg;
    logic [pei_pkg::DATA_W-1:0]         rem_reg;
    logic [pei_pkg::DATA_W-1:0]         dq_reg;
    logic [pei_pkg::DATA_W-1:0]         den_reg;
    logic                               ovf_reg;
    logic [pei_pkg::DATA_W-1:0]         rem_next;
    logic [pei_pkg::DATA_W-1:0]         dq_next;

    // restoring steps; dq shifts dividend bits out and quotient bits in
    always_comb begin
        logic [pei_pkg::DATA_W:0] trial;
        rem_next = rem_reg;
        dq_next  = dq_reg;
        trial    = '0;
        for (int k = 0; k < pei_pkg::DIV_STEPS; k++) begin
            trial   = {rem_next, dq_next[pei_pkg::DATA_W-1]};
            dq_next = {dq_next[pei_pkg::DATA_W-2:0], 1'b0};
            if (trial >= {1'b0, den_reg}) begin
                rem_next   = pei_pkg::DATA_W'(trial - {1'b0, den_reg});
                dq_next[0] = 1'b1;
            end else begin
                rem_next = trial[pei_pkg::DATA_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                if (cnt_reg == CNT_LAST) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= dividend[pei_pkg::MAG_W-1:pei_pkg::DATA_W];
            dq_reg  <= dividend[pei_pkg::DATA_W-1:0];
            den_reg <= divisor;
            // quotient of 2^32 or more: caller saturates
            ovf_reg <= (dividend[pei_pkg::MAG_W-1:pei_pkg::DATA_W] >= divisor);
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            dq_reg  <= dq_next;
        end
    end

    assign done = done_reg;
    assign ovf  = ovf_reg;
    assign quot = dq_reg;

endmodule

>>> hw/rtl/pei_lane.sv
`timescale 1ns / 1ps

module pei_lane (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  pei_pkg::job_t        job,
    input  pei_pkg::axis_in_t    axis,
    output logic                 done,
    output pei_pkg::axis_out_t   result
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_LOAD,
        ST_WAIT,
        ST_POST
    } state_t;

    typedef enum logic [2:0] {
        OP_DRAG,
        OP_FORCE,
        OP_SPRING,
        OP_DAMP,
        OP_VEL,
        OP_POS
    } op_t;

    localparam logic signed [pei_pkg::ACC_W-1:0] ACC_MAX = 35'sh0_7FFF_FFFF;
    localparam logic signed [pei_pkg::ACC_W-1:0] ACC_MIN = 35'sh7_8000_0000;
    localparam logic [pei_pkg::QS_W-1:0]         Q_OVF   = 34'h1_0000_0000;

    function automatic logic signed [pei_pkg::DATA_W-1:0] sat32(
        input logic signed [pei_pkg::ACC_W-1:0] v
    );
        if (v > ACC_MAX) begin
            return 32'sh7FFF_FFFF;
        end else if (v < ACC_MIN) begin
            return 32'sh8000_0000;
        end
        return v[pei_pkg::DATA_W-1:0];
    endfunction

    state_t                                 state_reg;
    op_t                                    op_reg;
    logic                                   done_reg;
    logic signed [pei_pkg::PROD_W-1:0]      prod_reg;
    logic signed [pei_pkg::ACC_W-1:0]       acc_reg;
    logic signed [pei_pkg::DATA_W-1:0]      acc32_reg;
    logic signed [pei_pkg::DATA_W-1:0]      nv_reg;
    logic signed [pei_pkg::DATA_W-1:0]      np_reg;

    logic signed [pei_pkg::MUL_W-1:0]       mul_a;
    logic signed [pei_pkg::MUL_W-1:0]       mul_b;
    logic signed [pei_pkg::PROD_W-1:0]      prod_full;
    logic signed [pei_pkg::PROD_W-1:0]      prod_abs;
    logic [pei_pkg::DATA_W-1:0]             divisor_sel;
    logic                                   div_done;
    logic                                   div_ovf;
    logic [pei_pkg::DATA_W-1:0]             div_quot;
    logic [pei_pkg::QS_W-1:0]               q_mag;
    logic signed [pei_pkg::QS_W-1:0]        qs;
    logic signed [pei_pkg::ACC_W-1:0]       qs_ext;
    logic signed [pei_pkg::DATA_W-1:0]      term;
    logic signed [pei_pkg::ACC_W-1:0]       term_ext;
    logic signed [pei_pkg::ACC_W-1:0]       acc_post;
    logic signed [pei_pkg::ACC_W-1:0]       vel_sum;
    logic signed [pei_pkg::ACC_W-1:0]       pos_sum;

    // multiplier operands per step; force and damping use x 2^16
    always_comb begin
        mul_a       = '0;
        mul_b       = '0;
        divisor_sel = job.mass;
        case (op_reg)
            OP_DRAG: begin
                mul_a = $signed({axis.vel[31], axis.vel});
                mul_b = $signed({2'b00, job.drag});
            end
            OP_FORCE: begin
                mul_a = $signed({axis.force_c[31], axis.force_c});
                mul_b = $signed({1'b0, pei_pkg::Q16_ONE});
            end
            OP_SPRING: begin
                mul_a = $signed({axis.tgt[31], axis.tgt}) - $signed({axis.pos[31], axis.pos});
                mul_b = $signed({job.gain[31], job.gain});
            end
            OP_DAMP: begin
                mul_a = $signed({job.damp[31], job.damp});
                mul_b = $signed({1'b0, pei_pkg::Q16_ONE});
            end
            OP_VEL: begin
                mul_a       = $signed({acc32_reg[31], acc32_reg});
                mul_b       = $signed({1'b0, job.delta});
                divisor_sel = pei_pkg::MS_PER_S;
            end
            OP_POS: begin
                mul_a       = $signed({nv_reg[31], nv_reg});
                mul_b       = $signed({1'b0, job.delta});
                divisor_sel = pei_pkg::MS_PER_S;
            end
            default: begin
                mul_a = '0;
            end
        endcase
    end

    assign prod_full = mul_a * mul_b;
    assign prod_abs  = prod_reg[pei_pkg::PROD_W-1] ? -prod_reg : prod_reg;

    pei_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (state_reg == ST_LOAD),
        .dividend (prod_abs[pei_pkg::MAG_W-1:0]),
        .divisor  (divisor_sel),
        .done     (div_done),
        .ovf      (div_ovf),
        .quot     (div_quot)
    );

    // truncating division: divide magnitudes, then restore the sign
    assign q_mag    = div_ovf ? Q_OVF : {2'b00, div_quot};
    assign qs       = prod_reg[pei_pkg::PROD_W-1] ? -$signed(q_mag) : $signed(q_mag);
    assign qs_ext   = $signed({qs[pei_pkg::QS_W-1], qs});
    assign term     = sat32(qs_ext);
    assign term_ext = $signed({{3{term[31]}}, term});
    assign acc_post = (op_reg == OP_DRAG || op_reg == OP_DAMP) ? acc_reg - term_ext
                                                               : acc_reg + term_ext;
    assign vel_sum  = $signed({{3{axis.vel[31]}}, axis.vel}) + qs_ext;
    assign pos_sum  = $signed({{3{axis.pos[31]}}, axis.pos}) + qs_ext;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            op_reg    <= OP_DRAG;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    if (start) begin
                        op_reg    <= OP_DRAG;
                        acc_reg   <= axis.acc_init;
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    prod_reg  <= prod_full;
                    state_reg <= ST_LOAD;
                end
                ST_LOAD: begin
                    state_reg <= ST_WAIT;
                end
                ST_WAIT: begin
                    if (div_done) begin
                        state_reg <= ST_POST;
                    end
                end
                ST_POST: begin
                    state_reg <= ST_MUL;
                    case (op_reg)
                        OP_DRAG: begin
                            acc_reg   <= acc_post;
                            acc32_reg <= sat32(acc_post);
                            op_reg    <= OP_FORCE;
                        end
                        OP_FORCE: begin
                            acc_reg   <= acc_post;
                            acc32_reg <= sat32(acc_post);
                            op_reg    <= job.follow ? OP_SPRING : OP_VEL;
                        end
                        OP_SPRING: begin
                            acc_reg   <= acc_post;
                            acc32_reg <= sat32(acc_post);
                            op_reg    <= OP_DAMP;
                        end
                        OP_DAMP: begin
                            acc_reg   <= acc_post;
                            acc32_reg <= sat32(acc_post);
                            op_reg    <= OP_VEL;
                        end
                        OP_VEL: begin
                            nv_reg <= sat32(vel_sum);
                            op_reg <= OP_POS;
                        end
                        OP_POS: begin
                            np_reg    <= sat32(pos_sum);
                            done_reg  <= 1'b1;
                            state_reg <= ST_IDLE;
                        end
                        default: begin
                            state_reg <= ST_IDLE;
                        end
                    endcase
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign done       = done_reg;
    assign result.vel = nv_reg;
    assign result.pos = np_reg;

endmodule

>>> hw/rtl/particle_euler_integrator.sv
`timescale 1ns / 1ps

// Semi-implicit Euler step for one particle in 3D, signed Q16.16 with saturation.
// The first request after reset only records its time stamp and echoes the
// position with moved = 0; each later request integrates velocity and returns
// the new position. Three identical lanes, one per axis, run side by side;
// each lane owns one 33x33 multiplier and one divider that retires two
// quotient bits per cycle, and that divider sets the rate. A lane runs four
// division steps (drag, force, velocity, position) without a target and six
// with one (plus spring and damping). The next request is taken while the
// previous result still waits on the m_ side. Configuration writes take
// effect at once and must only be issued while no request is in progress.
module particle_euler_integrator (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              cfg_wr_en,
    input  logic [pei_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [pei_pkg::DATA_W-1:0]        cfg_wdata,

    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [31:0]                       s_time_ms,
    input  logic signed [31:0]                s_pos_x,
    input  logic signed [31:0]                s_pos_y,
    input  logic signed [31:0]                s_pos_z,
    input  logic                              s_target_valid,
    input  logic signed [31:0]                s_target_x,
    input  logic signed [31:0]                s_target_y,
    input  logic signed [31:0]                s_target_z,

    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [31:0]                m_new_pos_x,
    output logic signed [31:0]                m_new_pos_y,
    output logic signed [31:0]                m_new_pos_z,
    output logic                              m_moved
);

    localparam int unsigned N = pei_pkg::NUM_AXES;

    typedef enum logic [pei_pkg::CFG_ADDR_W-1:0] {
        REG_GRAVITY,
        REG_AIR_DRAG,
        REG_MASS,
        REG_FORCE_X,
        REG_FORCE_Y,
        REG_FORCE_Z,
        REG_FOLLOW_GAIN,
        REG_FOLLOW_DAMPING
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_HOLD
    } state_t;

    // configuration
    logic signed [31:0]        gravity_reg;
    logic [30:0]               drag_reg;
    logic [30:0]               mass_reg;
    logic signed [31:0]        force_reg [N];
    logic signed [31:0]        gain_reg;
    logic signed [31:0]        damp_reg;

    // integrator state and request capture
    state_t                    state_reg;
    logic signed [31:0]        velocity_reg [N];
    logic [31:0]               last_time_reg;
    logic                      started_reg;
    logic signed [31:0]        pos_reg [N];
    logic signed [31:0]        tgt_reg [N];
    logic                      follow_reg;
    logic [31:0]               delta_reg;
    logic                      start_reg;
    logic [N-1:0]              done_seen_reg;
    logic signed [31:0]        res_pos_reg [N];
    logic                      res_moved_reg;
    logic                      m_valid_reg;
    logic signed [31:0]        m_pos_reg [N];
    logic                      m_moved_reg;

    pei_pkg::job_t             job;
    pei_pkg::axis_in_t         axis_in  [N];
    pei_pkg::axis_out_t        axis_out [N];
    logic [N-1:0]              lane_done;
    logic [N-1:0]              done_all;
    logic signed [pei_pkg::ACC_W-1:0] grav_neg;
    logic                      s_request;
    logic signed [31:0]        s_pos [N];
    logic signed [31:0]        s_tgt [N];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gravity_reg <= '0;
            drag_reg    <= '0;
            mass_reg    <= 31'd65536;
            for (int i = 0; i < N; i++) begin
                force_reg[i] <= '0;
            end
            gain_reg    <= '0;
            damp_reg    <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_GRAVITY:        gravity_reg  <= cfg_wdata;
                REG_AIR_DRAG:       drag_reg     <= cfg_wdata[30:0];
                REG_MASS:           mass_reg     <= cfg_wdata[30:0];
                REG_FORCE_X:        force_reg[0] <= cfg_wdata;
                REG_FORCE_Y:        force_reg[1] <= cfg_wdata;
                REG_FORCE_Z:        force_reg[2] <= cfg_wdata;
                REG_FOLLOW_GAIN:    gain_reg     <= cfg_wdata;
                REG_FOLLOW_DAMPING: damp_reg     <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign s_pos[0] = s_pos_x;
    assign s_pos[1] = s_pos_y;
    assign s_pos[2] = s_pos_z;
    assign s_tgt[0] = s_target_x;
    assign s_tgt[1] = s_target_y;
    assign s_tgt[2] = s_target_z;

    // zero mass acts as one LSB
    assign job.drag   = drag_reg;
    assign job.mass   = (mass_reg == '0) ? 32'd1 : {1'b0, mass_reg};
    assign job.gain   = gain_reg;
    assign job.damp   = damp_reg;
    assign job.follow = follow_reg;
    assign job.delta  = delta_reg;

    // gravity pulls along minus y
    assign grav_neg = -$signed({{3{gravity_reg[31]}}, gravity_reg});

    always_comb begin
        for (int i = 0; i < N; i++) begin
            axis_in[i].vel      = velocity_reg[i];
            axis_in[i].pos      = pos_reg[i];
            axis_in[i].tgt      = tgt_reg[i];
            axis_in[i].force_c  = force_reg[i];
            axis_in[i].acc_init = (i == 1) ? grav_neg : '0;
        end
    end

    for (genvar g = 0; g < N; g++) begin : g_lane
        pei_lane u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .start   (start_reg),
            .job     (job),
            .axis    (axis_in[g]),
            .done    (lane_done[g]),
            .result  (axis_out[g])
        );
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_request = s_valid && s_ready;
    assign done_all  = done_seen_reg | lane_done;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            started_reg   <= 1'b0;
            last_time_reg <= '0;
            start_reg     <= 1'b0;
            done_seen_reg <= '0;
            m_valid_reg   <= 1'b0;
            for (int i = 0; i < N; i++) begin
                velocity_reg[i] <= '0;
            end
        end else begin
            start_reg <= 1'b0;
            if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_request) begin
                        for (int i = 0; i < N; i++) begin
                            pos_reg[i] <= s_pos[i];
                            tgt_reg[i] <= s_tgt[i];
                        end
                        follow_reg    <= s_target_valid;
                        // unsigned difference wraps when time runs backwards
                        delta_reg     <= s_time_ms - last_time_reg;
                        last_time_reg <= s_time_ms;
                        if (!started_reg) begin
                            started_reg   <= 1'b1;
                            for (int i = 0; i < N; i++) begin
                                res_pos_reg[i] <= s_pos[i];
                            end
                            res_moved_reg <= 1'b0;
                            state_reg     <= ST_HOLD;
                        end else begin
                            start_reg     <= 1'b1;
                            done_seen_reg <= '0;
                            state_reg     <= ST_RUN;
                        end
                    end
                end
                ST_RUN: begin
                    done_seen_reg <= done_all;
                    if (&done_all) begin
                        for (int i = 0; i < N; i++) begin
                            velocity_reg[i] <= axis_out[i].vel;
                            res_pos_reg[i]  <= axis_out[i].pos;
                        end
                        res_moved_reg <= 1'b1;
                        state_reg     <= ST_HOLD;
                    end
                end
                ST_HOLD: begin
                    if (!m_valid_reg || m_ready) begin
                        for (int i = 0; i < N; i++) begin
                            m_pos_reg[i] <= res_pos_reg[i];
                        end
                        m_moved_reg <= res_moved_reg;
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_new_pos_x = m_pos_reg[0];
    assign m_new_pos_y = m_pos_reg[1];
    assign m_new_pos_z = m_pos_reg[2];
    assign m_moved     = m_moved_reg;

endmodule

>>> hw/rtl/pei_checker.sv
`timescale 1ns / 1ps

module pei_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [pei_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [pei_pkg::DATA_W-1:0]        cfg_wdata,
    input  logic                              s_valid,
    input  logic                              s_ready,
    input  logic [31:0]                       s_time_ms,
    input  logic signed [31:0]                s_pos_x,
    input  logic signed [31:0]                s_pos_y,
    input  logic signed [31:0]                s_pos_z,
    input  logic                              s_target_valid,
    input  logic signed [31:0]                s_target_x,
    input  logic signed [31:0]                s_target_y,
    input  logic signed [31:0]                s_target_z,
    input  logic                              m_valid,
    input  logic                              m_ready,
    input  logic signed [31:0]                m_new_pos_x,
    input  logic signed [31:0]                m_new_pos_y,
    input  logic signed [31:0]                m_new_pos_z,
    input  logic                              m_moved
);

    logic       in_acc;
    logic       out_acc;
    logic [1:0] inflight_reg;
    logic       out_seen_reg;

    assign in_acc  = s_valid && s_ready;
    assign out_acc = m_valid && m_ready;

    // requests taken but not yet delivered
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inflight_reg <= '0;
            out_seen_reg <= 1'b0;
        end else begin
            inflight_reg <= inflight_reg + 2'(in_acc) - 2'(out_acc);
            if (out_acc) begin
                out_seen_reg <= 1'b1;
            end
        end
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_new_pos_x) && $stable(m_new_pos_y)
            && $stable(m_new_pos_z) && $stable(m_moved))
        else $error("result changed while stalled");

    // one request in the lanes plus one in the output register at most
    a_in_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        in_acc |-> inflight_reg != 2'd2 && inflight_reg != 2'd3)
        else $error("request taken with two outstanding");

    a_no_phantom: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> inflight_reg != 2'd0)
        else $error("result without a pending request");

    // only the first result after reset is an echo
    a_moved: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_moved == out_seen_reg)
        else $error("moved flag out of sequence");

endmodule

bind particle_euler_integrator pei_checker u_pei_checker (.*);

>>> verif/particle_euler_integrator_test.sv
`timescale 1ns / 1ps

module particle_euler_integrator_test;
    import pei_pkg::*;

    typedef logic signed [95:0] wide_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_GRAVITY,
        REG_AIR_DRAG,
        REG_MASS,
        REG_FORCE_X,
        REG_FORCE_Y,
        REG_FORCE_Z,
        REG_FOLLOW_GAIN,
        REG_FOLLOW_DAMPING
    } cfg_reg_e;

    typedef struct packed {
        logic [31:0]      time_ms;
        logic [2:0][31:0] pos;
        logic             follow;
        logic [2:0][31:0] tgt;
    } request_t;

    typedef struct packed {
        logic [2:0][31:0] pos;
        logic             moved;
    } step_result_t;

    localparam wide_t SAT_HI = 96'sd2147483647;
    localparam wide_t SAT_LO = -96'sd2147483648;
    localparam wide_t Q_ONE  = 96'sd65536;
    localparam wide_t MS_DIV = 96'sd1000;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int TAIL_CYCLES    = 200;
    localparam int HOLD_CYCLES    = 600;
    localparam int PRINT_CAP      = 200;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [DATA_W-1:0]     cfg_wdata;
    logic                  s_valid;
    logic                  s_ready;
    request_t              s_req;
    logic                  m_valid;
    logic                  m_ready;
    logic signed [31:0]    m_new_pos_x;
    logic signed [31:0]    m_new_pos_y;
    logic signed [31:0]    m_new_pos_z;
    logic                  m_moved;

    // register mirror
    logic [31:0]      cfg_gravity;
    logic [30:0]      cfg_drag;
    logic [30:0]      cfg_mass;
    logic [2:0][31:0] cfg_force;
    logic [31:0]      cfg_gain;
    logic [31:0]      cfg_damping;

    // integrator state as the block should hold it
    logic [2:0][31:0] vel_state;
    logic [31:0]      last_ms;
    logic             started;

    step_result_t     pending_results[$];
    logic [31:0]      clock_ms;
    logic [2:0][31:0] trail_pos;

    int errors;
    int requests_sent;
    int results_checked;
    int settings_used;
    int idle_cycles;
    int sink_hold;
    bit src_idle;
    bit sink_idle;

    particle_euler_integrator dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_time_ms      (s_req.time_ms),
        .s_pos_x        (s_req.pos[0]),
        .s_pos_y        (s_req.pos[1]),
        .s_pos_z        (s_req.pos[2]),
        .s_target_valid (s_req.follow),
        .s_target_x     (s_req.tgt[0]),
        .s_target_y     (s_req.tgt[1]),
        .s_target_z     (s_req.tgt[2]),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_new_pos_x    (m_new_pos_x),
        .m_new_pos_y    (m_new_pos_y),
        .m_new_pos_z    (m_new_pos_z),
        .m_moved        (m_moved)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic wide_t sext32(logic [31:0] x);
        return {{64{x[31]}}, x};
    endfunction

    function automatic wide_t clamp32(wide_t x);
        if (x > SAT_HI) return SAT_HI;
        if (x < SAT_LO) return SAT_LO;
        return x;
    endfunction

    // One Euler step; updates the tracked velocity and time stamp.
    function automatic step_result_t euler_step(request_t rq);
        step_result_t res;
        wide_t delta, m, drag, damp, v, acc, nv, np;
        res.pos = rq.pos;
        res.moved = 1'b0;
        if (!started) begin
            started = 1'b1;
            last_ms = rq.time_ms;
            return res;
        end
        delta = {64'd0, rq.time_ms - last_ms};
        m = (cfg_mass == '0) ? 96'sd1 : wide_t'({65'd0, cfg_mass});
        drag = {65'd0, cfg_drag};
        damp = clamp32(sext32(cfg_damping) * Q_ONE / m);
        for (int i = 0; i < 3; i++) begin
            v = sext32(vel_state[i]);
            acc = '0;
            if (i == 1) acc = acc - sext32(cfg_gravity);
            acc = acc - clamp32(v * drag / m);
            acc = acc + clamp32(sext32(cfg_force[i]) * Q_ONE / m);
            if (rq.follow) begin
                acc = acc + clamp32((sext32(rq.tgt[i]) - sext32(rq.pos[i]))
                                    * sext32(cfg_gain) / m);
                acc = acc - damp;
            end
            acc = clamp32(acc);
            nv = clamp32(v + acc * delta / MS_DIV);
            vel_state[i] = nv[31:0];
            np = clamp32(sext32(rq.pos[i]) + nv * delta / MS_DIV);
            res.pos[i] = np[31:0];
        end
        last_ms = rq.time_ms;
        res.moved = 1'b1;
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        errors++;
        if (errors <= PRINT_CAP)
            $display("%0t mismatch %s: got %h, expected %h", $time, what, got, want);
    endtask

    // drop valid, wait for every outstanding result, then a short guard
    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(cfg_reg_e idx, logic [31:0] val);
        settle();
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_GRAVITY:        cfg_gravity  = val;
            REG_AIR_DRAG:       cfg_drag     = val[30:0];
            REG_MASS:           cfg_mass     = val[30:0];
            REG_FORCE_X:        cfg_force[0] = val;
            REG_FORCE_Y:        cfg_force[1] = val;
            REG_FORCE_Z:        cfg_force[2] = val;
            REG_FOLLOW_GAIN:    cfg_gain     = val;
            REG_FOLLOW_DAMPING: cfg_damping  = val;
            default: ;
        endcase
    endtask

    task automatic send_request(request_t rq);
        int gap;
        step_result_t want;
        gap = src_idle ? $urandom_range(0, 15) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_req   <= rq;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        want = euler_step(rq);
        pending_results.push_back(want);
        trail_pos = want.pos;
        clock_ms = rq.time_ms;
        requests_sent++;
    endtask

    function automatic request_t make_req(logic [31:0] t, logic follow,
                                          logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                                          logic [31:0] tx, logic [31:0] ty, logic [31:0] tz);
        request_t rq;
        rq.time_ms = t;
        rq.follow  = follow;
        rq.pos     = {pz, py, px};
        rq.tgt     = {tz, ty, tx};
        return rq;
    endfunction

    function automatic logic [31:0] draw_q16();
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: begin
                case ($urandom_range(0, 4))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'h0000_0000;
                    3: return 32'h0000_0001;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default: return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
        endcase
    endfunction

    // mostly a trajectory continuing from the last position, sometimes noise
    function automatic request_t next_random_request();
        request_t rq;
        if ($urandom_range(0, 9) < 8) begin
            rq.time_ms = clock_ms + $urandom_range(0, 60);
            rq.pos     = trail_pos;
            rq.follow  = $urandom_range(0, 1);
            for (int i = 0; i < 3; i++)
                rq.tgt[i] = trail_pos[i] + ($urandom_range(0, 32 << 16) - (16 << 16));
        end else begin
            rq.time_ms = $urandom;
            rq.follow  = $urandom_range(0, 1);
            for (int i = 0; i < 3; i++) begin
                rq.pos[i] = $urandom;
                rq.tgt[i] = $urandom;
            end
        end
        return rq;
    endfunction

    task automatic test_first_request();
        // first request only records time: echo with moved low
        send_request(make_req(32'd1000, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0,
                              32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
        // default registers: no force, nothing should move
        send_request(make_req(32'd1000, 1'b0, 32'h0001_0000, 32'hFFFF_0000, 32'h0,
                              32'h0, 32'h0, 32'h0));
        send_request(make_req(32'd1250, 1'b1, 32'h0001_0000, 32'hFFFF_0000, 32'h0,
                              32'h0050_0000, 32'h0, 32'hFFB0_0000));
        settings_used++;
    endtask

    task automatic test_gravity_and_drag();
        write_reg(REG_GRAVITY, 32'd642908);
        write_reg(REG_AIR_DRAG, 32'd32768);
        settings_used++;
        repeat (3)
            send_request(make_req(clock_ms + 100, 1'b0, trail_pos[0], trail_pos[1],
                                  trail_pos[2], '0, '0, '0));
    endtask

    task automatic test_force_and_mass();
        write_reg(REG_FORCE_X, 32'h0002_0000);
        write_reg(REG_FORCE_Y, 32'hFFFF_0000);
        write_reg(REG_FORCE_Z, 32'h7FFF_FFFF);
        write_reg(REG_MASS, 32'h0002_0000);
        settings_used++;
        repeat (2)
            send_request(make_req(clock_ms + 40, 1'b0, trail_pos[0], trail_pos[1],
                                  trail_pos[2], '0, '0, '0));
        // zero mass behaves as one LSB
        write_reg(REG_MASS, 32'h0);
        send_request(make_req(clock_ms + 1, 1'b0, 32'h0, 32'h0, 32'h0, '0, '0, '0));
        // bit 31 is outside the mass register
        write_reg(REG_MASS, 32'hFFFF_FFFF);
        send_request(make_req(clock_ms + 10, 1'b0, 32'h0, 32'h0, 32'h0, '0, '0, '0));
    endtask

    task automatic test_follow();
        write_reg(REG_MASS, 32'h0001_0000);
        write_reg(REG_FORCE_X, 32'h0);
        write_reg(REG_FORCE_Y, 32'h0);
        write_reg(REG_FORCE_Z, 32'h0);
        write_reg(REG_GRAVITY, 32'h0);
        write_reg(REG_FOLLOW_GAIN, 32'd16384);
        write_reg(REG_FOLLOW_DAMPING, 32'd6554);
        settings_used++;
        repeat (3)
            send_request(make_req(clock_ms + 50, 1'b1, 32'h0, 32'h0001_0000, 32'hFFFE_0000,
                                  32'h000A_0000, 32'hFFF6_0000, 32'h0003_0000));
        // targets are ignored without target_valid
        send_request(make_req(clock_ms + 50, 1'b0, trail_pos[0], trail_pos[1], trail_pos[2],
                              32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678));
        // widest spring product
        write_reg(REG_FOLLOW_GAIN, 32'h8000_0000);
        send_request(make_req(clock_ms + 1, 1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0,
                              32'h7FFF_FFFF, 32'h8000_0000, 32'h0));
    endtask

    task automatic test_time_wrap();
        write_reg(REG_FOLLOW_GAIN, 32'h0000_4000);
        write_reg(REG_FOLLOW_DAMPING, 32'h0);
        write_reg(REG_GRAVITY, 32'h0000_0100);
        settings_used++;
        // time stamp going backwards wraps to a huge step
        send_request(make_req(clock_ms - 5, 1'b0, 32'h0, 32'h0, 32'h0, '0, '0, '0));
        send_request(make_req(32'hFFFF_FFFF, 1'b0, 32'h0, 32'h0, 32'h0, '0, '0, '0));
        send_request(make_req(32'h0, 1'b1, 32'h0, 32'h0, 32'h0,
                              32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
    endtask

    task automatic test_saturation();
        write_reg(REG_GRAVITY, 32'h8000_0000);
        write_reg(REG_AIR_DRAG, 32'h7FFF_FFFF);
        write_reg(REG_FORCE_X, 32'h7FFF_FFFF);
        write_reg(REG_MASS, 32'h1);
        settings_used++;
        repeat (2)
            send_request(make_req(clock_ms + 1000, 1'b0, 32'h7FFF_FFFF, 32'h8000_0000,
                                  32'h7FFF_FFFF, '0, '0, '0));
        write_reg(REG_GRAVITY, 32'h7FFF_FFFF);
        send_request(make_req(clock_ms + 1000, 1'b1, 32'h8000_0000, 32'h7FFF_FFFF,
                              32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0));
    endtask

    task automatic load_random_settings(int flavor);
        logic [31:0] mass_val;
        case (flavor)
            1: begin
                write_reg(REG_GRAVITY, 32'h7FFF_FFFF);
                write_reg(REG_AIR_DRAG, 32'h7FFF_FFFF);
                write_reg(REG_MASS, 32'h7FFF_FFFF);
                write_reg(REG_FORCE_X, 32'h7FFF_FFFF);
                write_reg(REG_FORCE_Y, 32'h7FFF_FFFF);
                write_reg(REG_FORCE_Z, 32'h7FFF_FFFF);
                write_reg(REG_FOLLOW_GAIN, 32'h7FFF_FFFF);
                write_reg(REG_FOLLOW_DAMPING, 32'h7FFF_FFFF);
            end
            2: begin
                write_reg(REG_GRAVITY, 32'h8000_0000);
                write_reg(REG_AIR_DRAG, 32'h0);
                write_reg(REG_MASS, 32'h1);
                write_reg(REG_FORCE_X, 32'h8000_0000);
                write_reg(REG_FORCE_Y, 32'h8000_0000);
                write_reg(REG_FORCE_Z, 32'h8000_0000);
                write_reg(REG_FOLLOW_GAIN, 32'h8000_0000);
                write_reg(REG_FOLLOW_DAMPING, 32'h8000_0000);
            end
            default: begin
                // keep most masses near unity so the trajectory stays in range
                mass_val = ($urandom_range(0, 3) != 0) ? $urandom_range(32'h4000, 32'h4_0000)
                                                       : draw_q16();
                write_reg(REG_GRAVITY, draw_q16());
                write_reg(REG_AIR_DRAG, ($urandom_range(0, 3) != 0) ?
                                        $urandom_range(0, 32'h1_0000) : draw_q16());
                write_reg(REG_MASS, mass_val);
                write_reg(REG_FORCE_X, draw_q16());
                write_reg(REG_FORCE_Y, draw_q16());
                write_reg(REG_FORCE_Z, draw_q16());
                write_reg(REG_FOLLOW_GAIN, draw_q16());
                write_reg(REG_FOLLOW_DAMPING, draw_q16());
            end
        endcase
        settings_used++;
    endtask

    task automatic test_backpressure();
        load_random_settings(0);
        src_idle  = 1'b0;
        sink_idle = 1'b0;
        // output stalls long after the first result; input must back up
        sink_hold = HOLD_CYCLES;
        repeat (12) send_request(next_random_request());
        // sender waits for the block to empty completely
        settle();
        repeat (6) send_request(next_random_request());
    endtask

    task automatic test_random_phases();
        for (int phase = 0; phase < 8; phase++) begin
            src_idle  = phase[0];
            sink_idle = phase[1];
            load_random_settings(phase == 5 ? 1 : (phase == 6 ? 2 : 0));
            repeat (45) send_request(next_random_request());
        end
    endtask

    initial begin : result_sink
        int stall;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (sink_hold > 0) stall = sink_hold;
            else stall = sink_idle ? $urandom_range(0, 15) : 0;
            sink_hold = 0;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (m_valid !== 1'b1) @(posedge aclk);
        end
    end

    initial begin : result_check
        step_result_t want;
        idle_cycles = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && ((s_valid && s_ready) || (m_valid && m_ready))) idle_cycles = 0;
            else idle_cycles++;
            if (aresetn && m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("result with no request", m_new_pos_x, '0);
                end else begin
                    want = pending_results.pop_front();
                    results_checked++;
                    if (m_new_pos_x !== want.pos[0])
                        report_mismatch("new_pos_x", m_new_pos_x, want.pos[0]);
                    if (m_new_pos_y !== want.pos[1])
                        report_mismatch("new_pos_y", m_new_pos_y, want.pos[1]);
                    if (m_new_pos_z !== want.pos[2])
                        report_mismatch("new_pos_z", m_new_pos_z, want.pos[2]);
                    if (m_moved !== want.moved)
                        report_mismatch("moved", m_moved, want.moved);
                end
            end
        end
    end

    initial begin : watchdog
        wait (aresetn === 1'b1);
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge aclk);
        $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("[particle_euler_integrator] ERROR");
        $finish;
    end

    initial begin
        aresetn   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        s_valid   = 1'b0;
        s_req     = '0;
        errors          = 0;
        requests_sent   = 0;
        results_checked = 0;
        settings_used   = 0;
        sink_hold       = 0;
        src_idle        = 1'b0;
        sink_idle       = 1'b0;
        cfg_gravity = '0;
        cfg_drag    = '0;
        cfg_mass    = 31'd65536;
        cfg_force   = '0;
        cfg_gain    = '0;
        cfg_damping = '0;
        vel_state   = '0;
        last_ms     = '0;
        started     = 1'b0;
        clock_ms    = '0;
        trail_pos   = '0;

        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        test_first_request();
        test_gravity_and_drag();
        test_force_and_mass();
        test_follow();
        test_time_wrap();
        test_saturation();
        test_backpressure();
        test_random_phases();

        settle();
        repeat (TAIL_CYCLES) @(negedge aclk);
        if (pending_results.size() != 0)
            report_mismatch("results never delivered", '0, pending_results.size());

        $display("Checked %0d position updates from %0d requests over %0d register settings,",
                 results_checked, requests_sent, settings_used);
        $display("including random gaps on both sides, a long output stall and time wrap.");
        if (errors == 0) begin
            $display("[particle_euler_integrator] OK");
        end else begin
            $display("[particle_euler_integrator] ERROR");
        end
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/pei_pkg.sv
hw/rtl/pei_div.sv
hw/rtl/pei_lane.sv
hw/rtl/particle_euler_integrator.sv
hw/rtl/pei_checker.sv
verif/particle_euler_integrator_test.sv
